// ===== rtl/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants for the postfix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pee_pkg;

	localparam int DATA_W          = 32;
	localparam int SYM_W           = 8;
	localparam int STATUS_W        = 2;
	localparam int DEF_STACK_DEPTH = 32;

	localparam logic [SYM_W-1:0] SYM_POW  = 8'h5E;
	localparam logic [SYM_W-1:0] SYM_MUL  = 8'h2A;
	localparam logic [SYM_W-1:0] SYM_DIV  = 8'h2F;
	localparam logic [SYM_W-1:0] SYM_ADD  = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_SUB  = 8'h2D;
	localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;
	localparam logic [SYM_W-1:0] SYM_NINE = 8'h39;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_DIVZ  = 2'd2,
		ST_OVER  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ALU_ADD = 3'd0,
		ALU_SUB = 3'd1,
		ALU_MUL = 3'd2,
		ALU_DIV = 3'd3,
		ALU_POW = 3'd4
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

endpackage

`default_nettype wire

// ===== rtl/pee_ram.sv =====
// ----------------------------------------------------------------------------
// pee_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/pee_alu.sv =====
// ----------------------------------------------------------------------------
// pee_alu
// Iterative arithmetic unit: add, sub and mul in one step, restoring divide
// over 32 steps, power by square-and-multiply on one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_alu
	import pee_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire alu_req_t          req,
	input  wire logic [DATA_W-1:0] a,
	input  wire logic [DATA_W-1:0] b,
	output logic                   done,
	output logic      [DATA_W-1:0] result
);

	localparam int CNT_W = $clog2(DATA_W);

	typedef enum logic [2:0] {
		U_IDLE = 3'b001,
		U_RUN  = 3'b010,
		U_DONE = 3'b100
	} ustate_t;

	ustate_t             state_q;
	alu_op_t             op_q;
	logic [DATA_W-1:0]   x_q;
	logic [DATA_W-1:0]   y_q;
	logic [DATA_W-1:0]   z_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                neg_q;
	logic                phase_q;

	logic [DATA_W-1:0]   mul_a;
	logic [DATA_W-1:0]   mul_b;
	logic [2*DATA_W-1:0] prod_w;
	logic [DATA_W-1:0]   prod;
	logic [DATA_W:0]     rem_sh;
	logic [DATA_W:0]     diff;
	logic                qbit;
	logic [DATA_W-1:0]   abs_a;
	logic [DATA_W-1:0]   abs_b;
	logic [DATA_W-1:0]   pow_neg;

	assign mul_a  = (state_q == U_IDLE) ? a : (phase_q ? y_q : z_q);
	assign mul_b  = (state_q == U_IDLE) ? b : y_q;
	assign prod_w = mul_a * mul_b;
	assign prod   = prod_w[DATA_W-1:0];

	assign rem_sh = {z_q, x_q[DATA_W-1]};
	assign diff   = rem_sh - {1'b0, y_q};
	assign qbit   = ~diff[DATA_W];

	assign abs_a = a[DATA_W-1] ? (~a + 1'b1) : a;
	assign abs_b = b[DATA_W-1] ? (~b + 1'b1) : b;

	always_comb begin
		if (a == DATA_W'(1)) begin
			pow_neg = DATA_W'(1);
		end else if (a == {DATA_W{1'b1}}) begin
			pow_neg = b[0] ? {DATA_W{1'b1}} : DATA_W'(1);
		end else begin
			pow_neg = '0;
		end
	end

	assign done   = (state_q == U_DONE);
	assign result = (op_q == ALU_DIV) ? (neg_q ? (~x_q + 1'b1) : x_q) : z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
		end else begin
			case (state_q)
				U_IDLE: begin
					if (req.start) begin
						state_q <= ((req.op == ALU_DIV) || (req.op == ALU_POW && !b[DATA_W-1]))
							? U_RUN : U_DONE;
					end
				end
				U_RUN: begin
					if (op_q == ALU_DIV) begin
						if (cnt_q == CNT_W'(DATA_W - 1)) begin
							state_q <= U_DONE;
						end
					end else if (x_q == '0) begin
						state_q <= U_DONE;
					end
				end
				U_DONE: begin
					state_q <= U_IDLE;
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (req.start) begin
					op_q    <= req.op;
					cnt_q   <= '0;
					phase_q <= 1'b0;
					neg_q   <= a[DATA_W-1] ^ b[DATA_W-1];
					case (req.op)
						ALU_ADD: z_q <= a + b;
						ALU_SUB: z_q <= a - b;
						ALU_MUL: z_q <= prod;
						ALU_DIV: begin
							x_q <= abs_a;
							y_q <= abs_b;
							z_q <= '0;
						end
						ALU_POW: begin
							x_q <= b;
							y_q <= a;
							z_q <= b[DATA_W-1] ? pow_neg : DATA_W'(1);
						end
						default: z_q <= '0;
					endcase
				end
			end
			U_RUN: begin
				if (op_q == ALU_DIV) begin
					z_q   <= qbit ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
					x_q   <= {x_q[DATA_W-2:0], qbit};
					cnt_q <= cnt_q + 1'b1;
				end else if (x_q != '0) begin
					if (!phase_q) begin
						if (x_q[0]) begin
							z_q <= prod;
						end
						phase_q <= 1'b1;
					end else begin
						y_q     <= prod;
						x_q     <= x_q >> 1;
						phase_q <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression one character per item on a bounded stack.
// ----------------------------------------------------------------------------
// Digits, ignored characters and operators short of operands are handled in the
// idle state; add, sub, mul, divide and power run on the ALU, and a zero divisor
// skips it. Power squares on the shared multiplier per exponent bit, skipped for a
// negative exponent. A last item then reads the top of stack, skipped on an empty
// stack, and waits on the output register. One item is in work at a time.
// Reset clears the stack count, status and output valid, not the stack contents.
`default_nettype none

module postfix_expression_evaluator
	import pee_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [SYM_W-1:0]    s_axis_tdata,   // [7:0] symbol
	input  wire logic                s_axis_tlast,
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic      [DATA_W-1:0]   m_axis_tdata,   // [31:0] value
	output logic      [STATUS_W-1:0] m_axis_tuser    // [1:0] status
);

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b00000001,
		S_RD1    = 8'b00000010,
		S_RD2    = 8'b00000100,
		S_EXEC   = 8'b00001000,
		S_WAIT   = 8'b00010000,
		S_FIN    = 8'b00100000,
		S_FIN_RD = 8'b01000000,
		S_EMIT   = 8'b10000000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	status_t           err_q;
	alu_op_t           op_q;
	logic              last_q;
	logic [DATA_W-1:0] rhs_q;
	logic [DATA_W-1:0] fin_val_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] value_q;
	status_t           status_q;

	logic              accept;
	logic              is_digit;
	logic              is_op;
	alu_op_t           dec_op;
	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  cnt_m2;
	logic              full;
	logic              divz;
	logic              emit;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	alu_req_t          alu_req;
	logic              alu_done;
	logic [DATA_W-1:0] alu_result;

	logic              flag_en;
	status_t           flag_code;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = value_q;
	assign m_axis_tuser  = status_q;

	assign is_digit = (s_axis_tdata >= SYM_ZERO) && (s_axis_tdata <= SYM_NINE);
	assign cnt_m1   = count_q - 1'b1;
	assign cnt_m2   = count_q - CNT_W'(2);
	assign full     = (count_q == CNT_W'(STACK_DEPTH));
	assign divz     = (op_q == ALU_DIV) && (rhs_q == '0);
	assign emit     = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);

	always_comb begin
		is_op  = 1'b1;
		dec_op = ALU_ADD;
		case (s_axis_tdata)
			SYM_POW: dec_op = ALU_POW;
			SYM_MUL: dec_op = ALU_MUL;
			SYM_DIV: dec_op = ALU_DIV;
			SYM_ADD: dec_op = ALU_ADD;
			SYM_SUB: dec_op = ALU_SUB;
			default: is_op  = 1'b0;
		endcase
	end

	// stack port, ALU request and status flag control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_m2[ADDR_W-1:0];
		ram_wdata = alu_result;
		ram_raddr = (state_q == S_RD2) ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
		alu_req.start = 1'b0;
		alu_req.op    = op_q;
		flag_en   = 1'b0;
		flag_code = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept && is_digit) begin
					if (full) begin
						flag_en   = 1'b1;
						flag_code = ST_OVER;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = count_q[ADDR_W-1:0];
						ram_wdata = {{(DATA_W-4){1'b0}}, s_axis_tdata[3:0]};
					end
				end else if (accept && is_op && (count_q < CNT_W'(2))) begin
					flag_en   = 1'b1;
					flag_code = ST_UNDER;
				end
			end
			S_EXEC: begin
				if (divz) begin
					ram_we    = 1'b1;
					ram_wdata = '0;
					flag_en   = 1'b1;
					flag_code = ST_DIVZ;
				end else begin
					alu_req.start = 1'b1;
				end
			end
			S_WAIT: begin
				ram_we = alu_done;
			end
			S_FIN: begin
				if (count_q == '0) begin
					flag_en   = 1'b1;
					flag_code = ST_UNDER;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready && !emit) begin
				out_valid_q <= 1'b0;
			end
			if (flag_en && (err_q == ST_OK)) begin
				err_q <= flag_code;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_digit && !full) begin
							count_q <= count_q + 1'b1;
						end
						if (is_op && (count_q >= CNT_W'(2))) begin
							state_q <= S_RD1;
						end else if (s_axis_tlast) begin
							state_q <= S_FIN;
						end
					end
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_EXEC;
				S_EXEC: begin
					if (divz) begin
						count_q <= cnt_m1;
						state_q <= last_q ? S_FIN : S_IDLE;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (alu_done) begin
						count_q <= cnt_m1;
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					state_q <= (count_q == '0) ? S_EMIT : S_FIN_RD;
				end
				S_FIN_RD: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						count_q     <= '0;
						err_q       <= ST_OK;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= dec_op;
			last_q <= s_axis_tlast;
		end
		if (state_q == S_RD2) begin
			rhs_q <= ram_rdata;
		end
		if (state_q == S_FIN) begin
			fin_val_q <= '0;
		end
		if (state_q == S_FIN_RD) begin
			fin_val_q <= ram_rdata;
		end
		if (emit) begin
			value_q  <= fin_val_q;
			status_q <= err_q;
		end
	end

	pee_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pee_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.a     (ram_rdata),
		.b     (rhs_q),
		.done  (alu_done),
		.result(alu_result)
	);

endmodule

`default_nettype wire
